[hdl/touch_panel_frame_parser_macros.svh]
`ifndef TOUCH_PANEL_FRAME_PARSER_MACROS_SVH
`define TOUCH_PANEL_FRAME_PARSER_MACROS_SVH

// Implication check, sampled on the rising clock edge, off while in reset.
`define TPFP_ASSERT_IMPLY(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("tpfp implication check failed");

// Invariant check that must hold at every edge out of reset.
`define TPFP_ASSERT_ALWAYS(lbl, clk_s, rst_n_s, expr) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (expr)) \
		else $error("tpfp invariant check failed");

`endif

[hdl/tpfp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tpfp_pkg;

	localparam int MAX_PAYLOAD = 5;
	// largest byte index ever held is MAX_PAYLOAD+4
	localparam int CNT_W = $clog2(MAX_PAYLOAD + 5);

	localparam logic [7:0] SYNC0    = 8'hAA;
	localparam logic [7:0] SYNC1    = 8'h55;
	localparam logic [7:0] ARG_NONE = 8'hFF;

	localparam logic [7:0] CMD_DISTANCE = 8'd1;
	localparam logic [7:0] CMD_ANGLE    = 8'd2;
	localparam logic [7:0] CMD_FIRE     = 8'd3;

	// sync, sync, length and checksum bytes around the payload
	localparam logic [8:0] FRAME_OVERHEAD = 9'd4;
	localparam logic [7:0] DIST_LOW       = 8'd200;
	localparam logic [8:0] DIST_ADD       = 9'd255;
	localparam logic [8:0] DIST_RESET     = 9'd250;
	localparam logic [7:0] ANGLE_MAX      = 8'd128;
	localparam logic [8:0] ANGLE_SUB      = 9'd255;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// classified byte handed from front to back
	typedef struct packed {
		logic       ok;
		logic [7:0] cmd;
		logic [7:0] arg;
	} cls_t;

	typedef struct packed {
		logic              frame_ok;
		logic [7:0]        command_code;
		logic [8:0]        target_distance;
		logic signed [8:0] target_angle;
		logic              fire_request;
	} res_t;

endpackage

`default_nettype wire

[hdl/touch_panel_frame_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

// Touch panel frame parser: one received serial byte per push, one result per byte.
// A byte is taken every clock while full is low; its result passes through the
// classifier into a 2-entry queue, then through the command stage into a 2-entry
// result queue, from which it can be popped. Throughput is one byte per cycle
// while full is low, set by the combinational header/length/checksum classifier.
// frame_ok and fire_request flag the byte that closed a good frame; the other
// outputs show the current command, distance and angle settings.
module touch_panel_frame_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        rx_byte,
	output logic              empty,
	input  logic              pop,
	output logic              frame_ok,
	output logic [7:0]        command_code,
	output logic [8:0]        target_distance,
	output logic signed [8:0] target_angle,
	output logic              fire_request
);
	import tpfp_pkg::*;

	logic accept;
	cls_t cls;
	cls_t q_item;
	logic q_empty;
	logic q_pop;
	res_t res;

	assign accept = push && !full;

	tpfp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.cls     (cls)
	);

	tpfp_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_item (cls),
		.full    (full),
		.rd_en   (q_pop),
		.rd_item (q_item),
		.empty   (q_empty)
	);

	tpfp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.res     (res)
	);

	assign frame_ok        = res.frame_ok;
	assign command_code    = res.command_code;
	assign target_distance = res.target_distance;
	assign target_angle    = res.target_angle;
	assign fire_request    = res.fire_request;

endmodule

`default_nettype wire

[hdl/tpfp_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module tpfp_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     rx_byte,
	output tpfp_pkg::cls_t cls
);
	import tpfp_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [7:0]       sum_q;
	logic [7:0]       buf1_q;
	logic [7:0]       buf2_q;
	logic [7:0]       buf3_q;
	logic [7:0]       buf4_q;

	logic [CNT_W-1:0] held;
	logic             over;
	logic             hdr_bad;
	logic             past_len;
	logic             sync_bad;
	logic [8:0]       need;
	logic             done;
	logic             close;

	always_comb begin
		held     = count_q + CNT_W'(1);
		over     = count_q >= CNT_W'(MAX_PAYLOAD + 4);
		// byte 0 is only ever kept when it was the first sync byte
		hdr_bad  = (count_q == '0) && (rx_byte != SYNC0);
		past_len = count_q >= CNT_W'(3);
		sync_bad = past_len && (buf1_q != SYNC1);
		need     = {1'b0, buf2_q} + FRAME_OVERHEAD;
		done     = past_len && (9'(held) >= need);
		close    = over || hdr_bad || sync_bad || done;

		cls.ok  = !over && !hdr_bad && !sync_bad && done && (sum_q == rx_byte);
		// bypass the byte being written this cycle
		cls.cmd = (count_q == CNT_W'(3)) ? rx_byte : buf3_q;
		cls.arg = (count_q == CNT_W'(4)) ? rx_byte : buf4_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			buf1_q  <= '0;
			buf2_q  <= '0;
			buf3_q  <= '0;
			buf4_q  <= '0;
		end else if (accept) begin
			if (close) begin
				count_q <= '0;
				sum_q   <= '0;
			end else begin
				count_q <= held;
				sum_q   <= sum_q + rx_byte;
			end
			if (!over) begin
				case (count_q)
					CNT_W'(1): buf1_q <= rx_byte;
					CNT_W'(2): buf2_q <= rx_byte;
					CNT_W'(3): buf3_q <= rx_byte;
					CNT_W'(4): buf4_q <= rx_byte;
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

[hdl/tpfp_cmd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module tpfp_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  tpfp_pkg::cls_t wr_item,
	output logic           full,
	input  logic           rd_en,
	output tpfp_pkg::cls_t rd_item,
	output logic           empty
);
	import tpfp_pkg::*;

	cls_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = cnt_q == QCNT_W'(QDEPTH);
	assign empty   = cnt_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/tpfp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "touch_panel_frame_parser_macros.svh"

module tpfp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  tpfp_pkg::cls_t q_item,
	output logic           q_pop,
	input  logic           pop,
	output logic           empty,
	output tpfp_pkg::res_t res
);
	import tpfp_pkg::*;

	logic [7:0]        last_cmd_q;
	logic [8:0]        dist_q;
	logic signed [8:0] angle_q;

	logic [7:0]        cmd_n;
	logic [8:0]        dist_n;
	logic signed [8:0] angle_n;
	res_t              res_n;

	res_t              out_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] out_cnt_q;
	logic              take;
	logic              deq;

	assign take  = !q_empty && (out_cnt_q < QCNT_W'(QDEPTH));
	assign q_pop = take;
	assign empty = out_cnt_q == '0;
	assign deq   = pop && !empty;
	assign res   = out_mem_q[rd_ptr_q];

	always_comb begin
		cmd_n   = last_cmd_q;
		dist_n  = dist_q;
		angle_n = angle_q;
		if (q_item.ok) begin
			cmd_n = q_item.cmd;
			if (q_item.cmd == CMD_DISTANCE && q_item.arg != ARG_NONE) begin
				// low values get an offset, kept as the panel firmware does it
				dist_n = (q_item.arg < DIST_LOW) ? DIST_ADD + {1'b0, q_item.arg}
					: {1'b0, q_item.arg};
			end
			if (q_item.cmd == CMD_ANGLE) begin
				angle_n = (q_item.arg > ANGLE_MAX) ? $signed({1'b0, q_item.arg} - ANGLE_SUB)
					: $signed({1'b0, q_item.arg});
			end
		end
		res_n.frame_ok        = q_item.ok;
		res_n.command_code    = cmd_n;
		res_n.target_distance = dist_n;
		res_n.target_angle    = angle_n;
		res_n.fire_request    = q_item.ok && (q_item.cmd == CMD_FIRE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cmd_q <= '0;
			dist_q     <= DIST_RESET;
			angle_q    <= '0;
		end else if (take) begin
			last_cmd_q <= cmd_n;
			dist_q     <= dist_n;
			angle_q    <= angle_n;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_mem_q[wr_ptr_q] <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (take) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			case ({take, deq})
				2'b10:   out_cnt_q <= out_cnt_q + QCNT_W'(1);
				2'b01:   out_cnt_q <= out_cnt_q - QCNT_W'(1);
				default: out_cnt_q <= out_cnt_q;
			endcase
		end
	end

	`TPFP_ASSERT_ALWAYS(a_out_cnt_bound, clk, arst_n, out_cnt_q <= QCNT_W'(QDEPTH))
	`TPFP_ASSERT_IMPLY(a_fire_needs_ok, clk, arst_n, !empty && res.fire_request, res.frame_ok)
	`TPFP_ASSERT_IMPLY(a_fire_cmd, clk, arst_n, !empty && res.fire_request, res.command_code == CMD_FIRE)
	`TPFP_ASSERT_ALWAYS(a_dist_floor, clk, arst_n, dist_q >= {1'b0, DIST_LOW})

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import tpfp_pkg::*;

	localparam int BUF_DEPTH   = MAX_PAYLOAD + 5;
	localparam int HOLD_CYCLES = 300;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              push;
	logic              full;
	logic [7:0]        rx_byte;
	logic              empty;
	logic              pop;
	logic              frame_ok;
	logic [7:0]        command_code;
	logic [8:0]        target_distance;
	logic signed [8:0] target_angle;
	logic              fire_request;

	touch_panel_frame_parser dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.rx_byte         (rx_byte),
		.empty           (empty),
		.pop             (pop),
		.frame_ok        (frame_ok),
		.command_code    (command_code),
		.target_distance (target_distance),
		.target_angle    (target_angle),
		.fire_request    (fire_request)
	);

	// mirror of the parser state
	logic [7:0] rx_frame [BUF_DEPTH];
	int         rx_held;
	logic [7:0] rx_sum;
	logic [7:0] cur_cmd;
	logic [8:0] cur_dist;
	logic [8:0] cur_angle;

	res_t       pending_status [$];

	int          n_bytes;
	int          n_results;
	int          n_errors;
	int          n_good;
	int          n_fire;
	int          n_full;
	int          burst_left;
	bit          gaps_on;
	bit          hold_req;
	int          hold_left;
	logic [31:0] rx_cycle;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic res_t parse_byte(input logic [7:0] b);
		res_t       r;
		int         held;
		logic       ok;
		logic [7:0] arg;
		ok = 1'b0;
		if (rx_held >= MAX_PAYLOAD + 4) begin
			// byte past the longest frame: dropped
			rx_held = 0;
			rx_sum  = '0;
		end else begin
			rx_frame[rx_held] = b;
			held = rx_held + 1;
			if (rx_frame[0] != SYNC0 || (held > 3 && rx_frame[1] != SYNC1)) begin
				rx_held = 0;
				rx_sum  = '0;
			end else if (held > 3 && held >= int'(rx_frame[2]) + 4) begin
				ok      = (rx_sum == b);
				rx_held = 0;
				rx_sum  = '0;
			end else begin
				rx_held = held;
				rx_sum  = rx_sum + b;
			end
		end
		r = '0;
		if (ok) begin
			// argument always from payload byte 1, stale or not
			arg     = rx_frame[4];
			cur_cmd = rx_frame[3];
			if (cur_cmd == CMD_DISTANCE && arg != ARG_NONE)
				cur_dist = (arg < DIST_LOW) ? DIST_ADD + {1'b0, arg} : {1'b0, arg};
			if (cur_cmd == CMD_ANGLE)
				cur_angle = (arg > ANGLE_MAX) ? {1'b0, arg} - ANGLE_SUB : {1'b0, arg};
			r.fire_request = (cur_cmd == CMD_FIRE);
		end
		r.frame_ok        = ok;
		r.command_code    = cur_cmd;
		r.target_distance = cur_dist;
		r.target_angle    = cur_angle;
		return r;
	endfunction

	task automatic flag_error(input string msg);
		n_errors++;
		if (n_errors <= 10)
			$display("%0t ns: %s", $realtime, msg);
	endtask

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on) begin
				gap = $urandom_range(1, 6);
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push    <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (full) begin
			n_full++;
			@(posedge clk);
		end
		pending_status.push_back(parse_byte(b));
		n_bytes++;
	endtask

	task automatic send_frame(input logic [7:0] sync1, input logic [7:0] len, input int n_pay,
		input logic [7:0] cmd, input logic [7:0] arg, input logic [7:0] sum_err);
		logic [7:0] sum;
		logic [7:0] b;
		sum = SYNC0 + sync1 + len;
		send_byte(SYNC0);
		send_byte(sync1);
		send_byte(len);
		for (int i = 0; i < n_pay; i++) begin
			if (i == 0)
				b = cmd;
			else if (i == 1)
				b = arg;
			else
				b = 8'($urandom_range(255));
			sum = sum + b;
			send_byte(b);
		end
		send_byte(sum + sum_err);
	endtask

	function automatic logic [7:0] pick_cmd();
		case ($urandom_range(7))
			0, 1: return CMD_DISTANCE;
			2, 3: return CMD_ANGLE;
			4, 5: return CMD_FIRE;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [7:0] pick_arg();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return DIST_LOW - 8'd1;
			2: return DIST_LOW;
			3: return ANGLE_MAX;
			4: return ANGLE_MAX + 8'd1;
			5: return ARG_NONE;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic test_directed();
		send_byte(8'h00);
		send_byte(8'hFF);
		// zero length: checksum lands in the command slot
		send_frame(SYNC1, 8'd0, 0, 8'h00, 8'h00, 8'd0);
		send_frame(SYNC1, 8'd2, 2, CMD_DISTANCE, DIST_LOW - 8'd1, 8'd0);
		// one-byte payload: checksum lands in the argument slot
		send_frame(SYNC1, 8'd1, 1, CMD_FIRE, 8'h00, 8'd0);
		send_frame(SYNC1, 8'd2, 2, CMD_ANGLE, ANGLE_MAX + 8'd1, 8'd0);
		send_frame(SYNC1, 8'd0, 0, 8'h00, 8'h00, 8'd1);
	endtask

	task automatic test_random_traffic(input int n_items);
		int stop_at;
		int kind;
		int n_pay;
		stop_at = n_bytes + n_items;
		while (n_bytes < stop_at) begin
			if ($urandom_range(15) == 0)
				gaps_on = !gaps_on;
			kind  = $urandom_range(99);
			n_pay = $urandom_range(MAX_PAYLOAD);
			if (kind < 70) begin
				send_frame(SYNC1, 8'(n_pay), n_pay, pick_cmd(), pick_arg(), 8'd0);
			end else if (kind < 80) begin
				send_frame(SYNC1, 8'(n_pay), n_pay, pick_cmd(), pick_arg(),
					8'($urandom_range(1, 255)));
			end else if (kind < 86) begin
				send_frame(SYNC1 ^ 8'($urandom_range(1, 255)), 8'(n_pay), n_pay, pick_cmd(),
					pick_arg(), 8'd0);
			end else if (kind < 93) begin
				// length byte disagrees with the payload, often overlong
				send_frame(SYNC1, 8'($urandom_range(255)), $urandom_range(MAX_PAYLOAD + 3),
					pick_cmd(), pick_arg(), 8'd0);
			end else begin
				repeat ($urandom_range(1, 6))
					send_byte($urandom_range(1) ? SYNC0 : 8'($urandom_range(255)));
			end
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_full_stall();
		gaps_on  = 1'b0;
		hold_req = 1'b1;
		repeat (8)
			send_frame(SYNC1, 8'd3, 3, pick_cmd(), pick_arg(), 8'd0);
		gaps_on = 1'b1;
	endtask

	// result side: check each popped transaction, then pick the next pop
	always @(posedge clk) begin : result_side
		res_t want;
		rx_cycle = rx_cycle + 1;
		if (arst_n && pop && !empty) begin
			n_results++;
			if (pending_status.size() == 0) begin
				flag_error($sformatf("unexpected result ok=%b cmd=%h", frame_ok, command_code));
			end else begin
				want = pending_status.pop_front();
				if (frame_ok !== want.frame_ok || command_code !== want.command_code ||
					target_distance !== want.target_distance ||
					target_angle !== want.target_angle ||
					fire_request !== want.fire_request)
					flag_error($sformatf({"result %0d: got ok=%b cmd=%h dist=%0d ang=%0d ",
						"fire=%b, expected ok=%b cmd=%h dist=%0d ang=%0d fire=%b"},
						n_results, frame_ok, command_code, target_distance, target_angle,
						fire_request, want.frame_ok, want.command_code, want.target_distance,
						$signed(want.target_angle), want.fire_request));
				if (want.frame_ok)
					n_good++;
				if (want.fire_request)
					n_fire++;
			end
		end
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (!arst_n || hold_left > 0) begin
			if (hold_left > 0)
				hold_left--;
			pop <= 1'b0;
		end else begin
			case (rx_cycle[8:7])
				2'd0: pop <= 1'b1;
				2'd1: pop <= 1'($urandom_range(1));
				2'd2: pop <= (rx_cycle[2:0] != 3'd5 && rx_cycle[2:0] != 3'd6);
				default: pop <= ($urandom_range(3) == 0);
			endcase
		end
	end

	initial begin
		arst_n     = 1'b0;
		push       = 1'b0;
		pop        = 1'b0;
		rx_byte    = '0;
		hold_req   = 1'b0;
		hold_left  = 0;
		rx_cycle   = '0;
		burst_left = 0;
		gaps_on    = 1'b1;
		n_bytes    = 0;
		n_results  = 0;
		n_errors   = 0;
		n_good     = 0;
		n_fire     = 0;
		n_full     = 0;
		for (int i = 0; i < BUF_DEPTH; i++)
			rx_frame[i] = '0;
		rx_held   = 0;
		rx_sum    = '0;
		cur_cmd   = '0;
		cur_dist  = DIST_RESET;
		cur_angle = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_traffic(760);
		test_full_stall();

		push <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d bytes and checked %0d results, %0d good frames, %0d fire requests.",
			n_bytes, n_results, n_good, n_fire);
		$display("Input held off by full for %0d cycles; %0d mismatches.", n_full, n_errors);
		if (n_errors == 0)
			$display("** touch_panel_frame_parser: PASSED **");
		else
			$display("** touch_panel_frame_parser: FAILED **");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout with %0d results still expected.", pending_status.size());
		$display("** touch_panel_frame_parser: FAILED **");
		$finish;
	end

endmodule
